// ===== hw/rtl/rgpr_pkg.sv =====
// Shared constants, tables and types for the ring gauge pixel renderer.
`default_nettype none
package rgpr_pkg;

    localparam int LINE_WIDTH_DEF   = 240;
    localparam int MARKER_OUTER_DEF = 6;
    localparam int MARKER_INNER_DEF = 3;

    // register map indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CENTER_COL     = 3'd0;
    localparam logic [2:0] REG_CENTER_ROW     = 3'd1;
    localparam logic [2:0] REG_OUTER_RADIUS   = 3'd2;
    localparam logic [2:0] REG_RING_THICKNESS = 3'd3;
    localparam logic [2:0] REG_SHOWN_VALUE    = 3'd4;
    localparam logic [2:0] REG_SCALE_MIN      = 3'd5;
    localparam logic [2:0] REG_SCALE_MAX      = 3'd6;

    // angles in Q16 degrees
    localparam int DEG45  = 45 * 65536;
    localparam int DEG90  = 90 * 65536;
    localparam int DEG180 = 180 * 65536;
    localparam int DEG225 = 225 * 65536;
    localparam int DEG315 = 315 * 65536;
    localparam int DEG360 = 360 * 65536;

    localparam int CORDIC_ITERS = 16;
    // round(0.6072529 * 65536), CORDIC gain compensation
    localparam int CORDIC_GAIN_INV = 39797;
    // reciprocal of 270 for exact floor division of 25-bit numerators
    localparam longint RECIP_SHIFT = 34;
    localparam longint RECIP_270   = ((64'd1 << RECIP_SHIFT) + 64'd269) / 64'd270;

    typedef enum logic [4:0] {
        ST_SETUP = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_ANG   = 5'b00100,
        ST_ROT   = 5'b01000,
        ST_IDLE  = 5'b10000
    } t_mk_state;

    function automatic logic [21:0] atan_q16(input logic [3:0] idx);
        logic [21:0] v;
        case (idx)
            4'd0:    v = 22'd2949120;
            4'd1:    v = 22'd1740967;
            4'd2:    v = 22'd919879;
            4'd3:    v = 22'd466945;
            4'd4:    v = 22'd234379;
            4'd5:    v = 22'd117304;
            4'd6:    v = 22'd58666;
            4'd7:    v = 22'd29335;
            4'd8:    v = 22'd14668;
            4'd9:    v = 22'd7334;
            4'd10:   v = 22'd3667;
            4'd11:   v = 22'd1833;
            4'd12:   v = 22'd917;
            4'd13:   v = 22'd458;
            4'd14:   v = 22'd229;
            4'd15:   v = 22'd115;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // rainbow stops, blue to red
    function automatic logic [15:0] stop_color(input logic [2:0] idx);
        logic [15:0] c;
        case (idx)
            3'd0:    c = 16'h001F;
            3'd1:    c = 16'h07FF;
            3'd2:    c = 16'h07E0;
            3'd3:    c = 16'hFFE0;
            3'd4:    c = 16'hFD20;
            3'd5:    c = 16'hF800;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ring_gauge_pixel_renderer_top.sv =====
// Ring gauge pixel renderer: APB registers, marker sequencer and pixel pipeline.
// Throughput: one item per cycle while o_in_ready is high; the pixel path is a
// 23-stage pipeline with an unrolled 16-stage CORDIC, and a stalled output
// freezes all stages in place. After reset and after every register write the
// marker sequencer (divider plus iterative CORDIC) steps through its setup,
// divide, angle and rotate states (divide skipped when clamped), o_in_ready low.
// Reset is synchronous, active low; it clears valid bits and restores registers.
`default_nettype none
module ring_gauge_pixel_renderer_top
    import rgpr_pkg::*;
#(
    parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
    parameter int MARKER_OUTER = MARKER_OUTER_DEF,
    parameter int MARKER_INNER = MARKER_INNER_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [9:0]  i_pixel_col,
    input  wire  [9:0]  i_pixel_row,
    input  wire  [15:0] i_background_color,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_pixel_color
);

    localparam int CW = 28;   // pixel CORDIC x/y
    localparam int ZW = 27;   // pixel CORDIC angle
    localparam int MW = 30;   // marker CORDIC x/y
    localparam int TW = 26;   // marker CORDIC angle

    typedef struct packed {
        logic [15:0] bg;
        logic        line;
        logic        zero;
        logic        ring;
        logic        white;
        logic        black;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [9:0]  r_center_col, r_center_row;
    logic [8:0]  r_outer_radius, r_ring_thickness;
    logic [15:0] r_shown_value, r_scale_min, r_scale_max;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col     <= 10'd120;
            r_center_row     <= 10'd120;
            r_outer_radius   <= 9'd100;
            r_ring_thickness <= 9'd16;
            r_shown_value    <= 16'd400;
            r_scale_min      <= 16'd400;
            r_scale_max      <= 16'd2000;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_CENTER_COL:     r_center_col     <= pwdata[9:0];
                REG_CENTER_ROW:     r_center_row     <= pwdata[9:0];
                REG_OUTER_RADIUS:   r_outer_radius   <= pwdata[8:0];
                REG_RING_THICKNESS: r_ring_thickness <= pwdata[8:0];
                REG_SHOWN_VALUE:    r_shown_value    <= pwdata[15:0];
                REG_SCALE_MIN:      r_scale_min      <= pwdata[15:0];
                REG_SCALE_MAX:      r_scale_max      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CENTER_COL:     prdata = {22'd0, r_center_col};
            REG_CENTER_ROW:     prdata = {22'd0, r_center_row};
            REG_OUTER_RADIUS:   prdata = {23'd0, r_outer_radius};
            REG_RING_THICKNESS: prdata = {23'd0, r_ring_thickness};
            REG_SHOWN_VALUE:    prdata = {16'd0, r_shown_value};
            REG_SCALE_MIN:      prdata = {16'd0, r_scale_min};
            REG_SCALE_MAX:      prdata = {16'd0, r_scale_max};
            default:            prdata = 32'd0;
        endcase
    end

    // squared ring bounds; inner radius may go negative
    logic [17:0]        r_outer_sq, r_inner_sq;
    logic signed [9:0]  inner_rad;
    logic signed [19:0] inner_sq;
    assign inner_rad = $signed({1'b0, r_outer_radius}) - $signed({1'b0, r_ring_thickness});
    assign inner_sq  = inner_rad * inner_rad;

    always_ff @(posedge i_clk) begin
        r_outer_sq <= r_outer_radius * r_outer_radius;
        r_inner_sq <= inner_sq[17:0];
    end

    // ---------------- marker sequencer ----------------
    t_mk_state              r_mk_state;
    logic [3:0]             r_mk_iter;
    logic [15:0]            r_mk_rem, r_mk_q;
    logic [16:0]            r_mk_p;
    logic signed [MW-1:0]   r_mk_x, r_mk_y;
    logic signed [TW-1:0]   r_mk_th;
    logic                   r_mk_neg;
    logic signed [12:0]     r_mc, r_mr;
    logic                   mk_busy;

    logic [15:0]            den;
    logic [16:0]            rem_sh;
    logic                   q_bit;
    logic [16:0]            rem_sub;
    logic [25:0]            p_scaled;
    logic signed [TW-1:0]   th0;
    logic signed [10:0]     rpos2;
    logic signed [MW-1:0]   mk_sx, mk_sy, mk_xf, mk_yf;
    logic signed [TW-1:0]   mk_at;
    logic signed [12:0]     off_c, off_r;

    function automatic logic signed [12:0] trunc17(input logic signed [MW-1:0] v);
        logic [MW-1:0] a;
        logic [12:0]   m;
        a = v[MW-1] ? MW'(-v) : MW'(v);
        m = a[MW-1:17];
        return v[MW-1] ? $signed(-m) : $signed(m);
    endfunction

    assign den      = r_scale_max - r_scale_min;
    assign rem_sh   = {r_mk_rem, 1'b0};
    assign q_bit    = rem_sh >= {1'b0, den};
    assign rem_sub  = rem_sh - {1'b0, den};
    assign p_scaled = r_mk_p * 9'd270;
    assign th0      = $signed(TW'(DEG225)) - $signed({1'b0, p_scaled[24:0]});
    assign rpos2    = $signed({1'b0, r_outer_radius, 1'b0}) -
                      $signed({2'b0, r_ring_thickness});
    assign mk_sx    = r_mk_x >>> r_mk_iter;
    assign mk_sy    = r_mk_y >>> r_mk_iter;
    assign mk_at    = $signed(TW'(atan_q16(r_mk_iter)));
    assign mk_xf    = r_mk_neg ? -r_mk_x : r_mk_x;
    assign mk_yf    = r_mk_neg ? -r_mk_y : r_mk_y;
    assign off_c    = trunc17(mk_xf);
    assign off_r    = trunc17(mk_yf);
    assign mk_busy  = r_mk_state != ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_mk_state <= ST_SETUP;
        end else begin
            case (r_mk_state)
                ST_SETUP: begin
                    r_mk_iter <= 4'd0;
                    r_mk_q    <= 16'd0;
                    r_mk_rem  <= r_shown_value - r_scale_min;
                    if (r_scale_max <= r_scale_min || r_shown_value <= r_scale_min) begin
                        r_mk_p     <= 17'd0;
                        r_mk_state <= ST_ANG;
                    end else if (r_shown_value >= r_scale_max) begin
                        r_mk_p     <= 17'h10000;
                        r_mk_state <= ST_ANG;
                    end else begin
                        r_mk_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_mk_rem  <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
                    r_mk_q    <= {r_mk_q[14:0], q_bit};
                    r_mk_iter <= r_mk_iter + 4'd1;
                    if (r_mk_iter == 4'(CORDIC_ITERS - 1)) begin
                        r_mk_p     <= {1'b0, r_mk_q[14:0], q_bit};
                        r_mk_state <= ST_ANG;
                    end
                end
                ST_ANG: begin
                    // fold angles above 90 degrees into range, negate result later
                    if (th0 > $signed(TW'(DEG90))) begin
                        r_mk_th  <= th0 - $signed(TW'(DEG180));
                        r_mk_neg <= 1'b1;
                    end else begin
                        r_mk_th  <= th0;
                        r_mk_neg <= 1'b0;
                    end
                    r_mk_x     <= MW'(rpos2 * $signed(18'(CORDIC_GAIN_INV)));
                    r_mk_y     <= '0;
                    r_mk_iter  <= 4'd0;
                    r_mk_state <= ST_ROT;
                end
                ST_ROT: begin
                    if (r_mk_th >= 0) begin
                        r_mk_x  <= r_mk_x - mk_sy;
                        r_mk_y  <= r_mk_y + mk_sx;
                        r_mk_th <= r_mk_th - mk_at;
                    end else begin
                        r_mk_x  <= r_mk_x + mk_sy;
                        r_mk_y  <= r_mk_y - mk_sx;
                        r_mk_th <= r_mk_th + mk_at;
                    end
                    r_mk_iter <= r_mk_iter + 4'd1;
                    if (r_mk_iter == 4'(CORDIC_ITERS - 1)) begin
                        r_mk_state <= ST_IDLE;
                    end
                end
                ST_IDLE: ;
                default: r_mk_state <= ST_SETUP;
            endcase
        end
    end

    // marker center follows the final rotation; stable while idle
    always_ff @(posedge i_clk) begin
        if (r_mk_state == ST_IDLE) begin
            r_mc <= $signed({3'b0, r_center_col}) + off_c;
            r_mr <= $signed({3'b0, r_center_row}) - off_r;
        end
    end

    // ---------------- pixel pipeline ----------------
    logic en, in_acc;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en && !mk_busy && r_mk_state == ST_IDLE;
    assign in_acc     = i_in_valid && o_in_ready;

    // stage 1: input register
    logic        r_v1;
    logic [9:0]  r_col1, r_row1;
    logic [15:0] r_bg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= in_acc;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col1 <= i_pixel_col;
            r_row1 <= i_pixel_row;
            r_bg1  <= i_background_color;
        end
    end

    // stage 2: offsets from gauge center and from marker center
    logic               r_v2, r_line2;
    logic signed [10:0] r_dx2, r_dy2;
    logic signed [13:0] r_mdx2, r_mdy2;
    logic [15:0]        r_bg2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en) r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx2   <= $signed({1'b0, r_col1}) - $signed({1'b0, r_center_col});
            r_dy2   <= $signed({1'b0, r_row1}) - $signed({1'b0, r_center_row});
            r_mdx2  <= $signed({4'b0, r_col1}) - $signed({r_mc[12], r_mc});
            r_mdy2  <= $signed({4'b0, r_row1}) - $signed({r_mr[12], r_mr});
            r_line2 <= {1'b0, r_col1} < 11'(LINE_WIDTH);
            r_bg2   <= r_bg1;
        end
    end

    // stage 3: squares and CORDIC setup (index 0 of the CORDIC chain)
    logic                r_cv   [0:CORDIC_ITERS];
    logic signed [CW-1:0] r_cx  [0:CORDIC_ITERS];
    logic signed [CW-1:0] r_cy  [0:CORDIC_ITERS];
    logic signed [ZW-1:0] r_cz  [0:CORDIC_ITERS];
    t_side                r_side[0:CORDIC_ITERS];
    logic signed [21:0]  r_sqx, r_sqy;
    logic signed [27:0]  r_sqmx, r_sqmy;
    logic signed [CW-1:0] dx_sc, dy_sc;

    assign dx_sc = $signed({{(CW-25){r_dx2[10]}}, r_dx2, 14'd0});
    assign dy_sc = $signed({{(CW-25){r_dy2[10]}}, r_dy2, 14'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv[0] <= 1'b0;
        else if (en) r_cv[0] <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx  <= r_dx2 * r_dx2;
            r_sqy  <= r_dy2 * r_dy2;
            r_sqmx <= r_mdx2 * r_mdx2;
            r_sqmy <= r_mdy2 * r_mdy2;
            if (r_dx2 < 0) begin
                r_cx[0] <= -dx_sc;
                r_cy[0] <= dy_sc;
                r_cz[0] <= $signed(ZW'(DEG180));
            end else begin
                r_cx[0] <= dx_sc;
                r_cy[0] <= -dy_sc;
                r_cz[0] <= '0;
            end
            r_side[0].bg    <= r_bg2;
            r_side[0].line  <= r_line2;
            r_side[0].zero  <= r_dx2 == 0 && r_dy2 == 0;
            r_side[0].ring  <= 1'b0;
            r_side[0].white <= 1'b0;
            r_side[0].black <= 1'b0;
        end
    end

    // ring and marker hits, joined into the side data at the first CORDIC stage
    logic [22:0]  dist2;
    logic [28:0]  md2;
    t_side        side_hit;
    assign dist2 = 23'(r_sqx) + 23'(r_sqy);
    assign md2   = 29'(r_sqmx) + 29'(r_sqmy);
    always_comb begin
        side_hit       = r_side[0];
        side_hit.ring  = dist2 <= {5'd0, r_outer_sq} && dist2 >= {5'd0, r_inner_sq};
        side_hit.white = md2 <= 29'(MARKER_OUTER * MARKER_OUTER);
        side_hit.black = md2 <= 29'(MARKER_INNER * MARKER_INNER);
    end

    for (genvar k = 1; k <= CORDIC_ITERS; k++) begin : g_cordic
        localparam int SH = k - 1;
        logic signed [CW-1:0] sx, sy;
        logic signed [ZW-1:0] at;
        assign sx = r_cx[k-1] >>> SH;
        assign sy = r_cy[k-1] >>> SH;
        assign at = $signed(ZW'(atan_q16(4'(SH))));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[k] <= 1'b0;
            else if (en) r_cv[k] <= r_cv[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                // a zero y leaves everything as it is
                if (r_cy[k-1] > 0) begin
                    r_cx[k] <= r_cx[k-1] + sy;
                    r_cy[k] <= r_cy[k-1] - sx;
                    r_cz[k] <= r_cz[k-1] + at;
                end else if (r_cy[k-1] < 0) begin
                    r_cx[k] <= r_cx[k-1] - sy;
                    r_cy[k] <= r_cy[k-1] + sx;
                    r_cz[k] <= r_cz[k-1] - at;
                end else begin
                    r_cx[k] <= r_cx[k-1];
                    r_cy[k] <= r_cy[k-1];
                    r_cz[k] <= r_cz[k-1];
                end
                r_side[k] <= (k == 1) ? side_hit : r_side[k-1];
            end
        end
    end

    // post 1: gauge angle, arc window, numerator of the arc fraction
    logic signed [ZW-1:0] z90, ang;
    logic                 r_pv1, r_arc1;
    logic [24:0]          r_num1;
    t_side                r_side1;

    assign z90 = r_cz[CORDIC_ITERS] + $signed(ZW'(DEG90));
    always_comb begin
        if (r_side[CORDIC_ITERS].zero) ang = $signed(ZW'(DEG90));
        else if (z90 < 0) ang = z90 + $signed(ZW'(DEG360));
        else if (z90 >= $signed(ZW'(DEG360))) ang = z90 - $signed(ZW'(DEG360));
        else ang = z90;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv1 <= 1'b0;
        else if (en) r_pv1 <= r_cv[CORDIC_ITERS];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_arc1  <= r_side[CORDIC_ITERS].ring && ang >= $signed(ZW'(DEG45)) &&
                       ang <= $signed(ZW'(DEG315));
            r_num1  <= 25'($signed(ZW'(DEG315)) - ang);
            r_side1 <= r_side[CORDIC_ITERS];
        end
    end

    // post 2: t = num / 270 by reciprocal multiply
    logic        r_pv2, r_arc2;
    logic [16:0] r_t2;
    logic [50:0] recip_prod;
    t_side       r_side2;
    assign recip_prod = r_num1 * 26'(RECIP_270);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv2 <= 1'b0;
        else if (en) r_pv2 <= r_pv1;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2    <= recip_prod[50:34];
            r_arc2  <= r_arc1;
            r_side2 <= r_side1;
        end
    end

    // post 3: segment, local fraction, end colors
    logic        r_pv3, r_arc3;
    logic [16:0] r_u3;
    logic [15:0] r_c1, r_c2;
    logic [18:0] s5;
    logic [2:0]  seg;
    t_side       r_side3;
    assign s5  = 19'(r_t2) * 19'd5;
    assign seg = (s5[18:16] > 3'd4) ? 3'd4 : s5[18:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv3 <= 1'b0;
        else if (en) r_pv3 <= r_pv2;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u3    <= 17'(s5 - {seg, 16'd0});
            r_c1    <= stop_color(seg);
            r_c2    <= stop_color(seg + 3'd1);
            r_arc3  <= r_arc2;
            r_side3 <= r_side2;
        end
    end

    // post 4: channel lerp and final select into the output register
    function automatic logic [5:0] lerp_ch(input logic [5:0] a, input logic [5:0] b,
                                           input logic [16:0] u);
        logic        neg;
        logic [5:0]  ad;
        logic [22:0] pr;
        neg = b < a;
        ad  = neg ? a - b : b - a;
        pr  = ad * u;
        return neg ? a - pr[21:16] : a + pr[21:16];
    endfunction

    logic [5:0]  lr, lg, lb;
    logic [15:0] arc_rgb, pix;
    logic        r_out_valid;
    logic [15:0] r_out_color;

    assign lr      = lerp_ch({1'b0, r_c1[15:11]}, {1'b0, r_c2[15:11]}, r_u3);
    assign lg      = lerp_ch(r_c1[10:5], r_c2[10:5], r_u3);
    assign lb      = lerp_ch({1'b0, r_c1[4:0]}, {1'b0, r_c2[4:0]}, r_u3);
    assign arc_rgb = {lr[4:0], lg, lb[4:0]};

    always_comb begin
        pix = r_side3.bg;
        if (r_side3.line) begin
            if (r_arc3) pix = arc_rgb;
            if (r_side3.white) pix = 16'hFFFF;
            if (r_side3.black) pix = 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (en) r_out_valid <= r_pv3;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_out_color <= pix;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_out_color;

endmodule
`default_nettype wire

// ===== tb/ring_gauge_pixel_renderer_checker.sv =====
// Checker for the ring gauge pixel renderer: predicts pixel colors and compares them.
module ring_gauge_pixel_renderer_checker
    import rgpr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    input  wire         i_in_valid,
    input  wire         o_in_ready,
    input  wire  [9:0]  i_pixel_col,
    input  wire  [9:0]  i_pixel_row,
    input  wire  [15:0] i_background_color,
    input  wire         o_out_valid,
    input  wire         i_out_ready,
    input  wire  [15:0] o_pixel_color,
    output int          o_fail_count,
    output int          o_pending
);

    logic [9:0]  cen_col, cen_row;
    logic [8:0]  rad, thick;
    logic [15:0] val, smin, smax;
    logic [15:0] color_q[$];

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint tdiv_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v) >>> s);
    endfunction

    function automatic longint angle_q16(int dx, int dy);
        longint x, y, z, nx, ny;
        z = 0;
        if (dx == 0 && dy == 0) return DEG90;
        x = longint'(dx) * 16384;
        y = -longint'(dy) * 16384;
        if (x < 0) begin
            x = -x; y = -y; z = DEG180;
        end
        for (int i = 0; i < 16; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + asr(y, i); ny = y - asr(x, i); z += atan_q16(i[3:0]);
            end else begin
                nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_q16(i[3:0]);
            end
            x = nx; y = ny;
        end
        z += DEG90;
        if (z < 0) z += DEG360;
        if (z >= DEG360) z -= DEG360;
        return z;
    endfunction

    function automatic int mix_chan(int a, int b, longint u);
        int d;
        longint m;
        d = b - a;
        m = ((d < 0 ? -d : d) * u) >> 16;
        return d < 0 ? a - int'(m) : a + int'(m);
    endfunction

    function automatic logic [15:0] rainbow(longint ang);
        longint t, s, u;
        int seg;
        logic [15:0] c1, c2;
        int r, g, b;
        t = (longint'(DEG315) - ang) / 270;
        s = t * 5;
        seg = int'(s >> 16);
        if (seg > 4) seg = 4;
        u = s - (longint'(seg) << 16);
        c1 = stop_color(seg[2:0]);
        c2 = stop_color(3'(seg + 1));
        r = mix_chan(c1[15:11], c2[15:11], u);
        g = mix_chan(c1[10:5], c2[10:5], u);
        b = mix_chan(c1[4:0], c2[4:0], u);
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    task automatic marker_center(output int mc, output int mr);
        longint p, th, x, y, nx, ny;
        bit neg;
        neg = 0;
        if (smax <= smin || val <= smin) p = 0;
        else if (val >= smax) p = 65536;
        else p = (longint'(val - smin) * 65536) / longint'(smax - smin);
        th = longint'(DEG315) - p * 270 - DEG90;
        if (th > DEG90) begin
            th -= DEG180; neg = 1;
        end
        x = (2 * longint'(rad) - longint'(thick)) * CORDIC_GAIN_INV;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (th >= 0) begin
                nx = x - asr(y, i); ny = y + asr(x, i); th -= atan_q16(i[3:0]);
            end else begin
                nx = x + asr(y, i); ny = y - asr(x, i); th += atan_q16(i[3:0]);
            end
            x = nx; y = ny;
        end
        if (neg) begin
            x = -x; y = -y;
        end
        mc = int'(cen_col) + int'(tdiv_shift(x, 17));
        mr = int'(cen_row) - int'(tdiv_shift(y, 17));
    endtask

    task automatic predict_color(input logic [9:0] col, input logic [9:0] row,
                                 input logic [15:0] bg, output logic [15:0] res);
        int dx, dy, d2, inr, mc, mr, md2;
        longint ang;
        res = bg;
        if (col < LINE_WIDTH_DEF) begin
            dx = int'(col) - int'(cen_col);
            dy = int'(row) - int'(cen_row);
            d2 = dx * dx + dy * dy;
            inr = int'(rad) - int'(thick);
            if (d2 <= int'(rad) * int'(rad) && d2 >= inr * inr) begin
                ang = angle_q16(dx, dy);
                if (ang >= DEG45 && ang <= DEG315) res = rainbow(ang);
            end
            marker_center(mc, mr);
            md2 = (int'(col) - mc) * (int'(col) - mc) + (int'(row) - mr) * (int'(row) - mr);
            if (md2 <= MARKER_OUTER_DEF * MARKER_OUTER_DEF) res = 16'hFFFF;
            if (md2 <= MARKER_INNER_DEF * MARKER_INNER_DEF) res = 16'h0000;
        end
    endtask

    assign o_pending = color_q.size();

    always @(posedge i_clk) begin
        logic [15:0] exp_c;
        if (!i_rst_n) begin
            cen_col <= 10'd120; cen_row <= 10'd120; rad <= 9'd100; thick <= 9'd16;
            val <= 16'd400; smin <= 16'd400; smax <= 16'd2000;
            color_q.delete();
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_CENTER_COL:     cen_col <= pwdata[9:0];
                    REG_CENTER_ROW:     cen_row <= pwdata[9:0];
                    REG_OUTER_RADIUS:   rad <= pwdata[8:0];
                    REG_RING_THICKNESS: thick <= pwdata[8:0];
                    REG_SHOWN_VALUE:    val <= pwdata[15:0];
                    REG_SCALE_MIN:      smin <= pwdata[15:0];
                    REG_SCALE_MAX:      smax <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_color(i_pixel_col, i_pixel_row, i_background_color, exp_c);
                color_q.push_back(exp_c);
            end
            if (o_out_valid && i_out_ready) begin
                if (color_q.size() == 0) begin
                    $display("%0t: unexpected pixel color %h", $time, o_pixel_color);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_c = color_q.pop_front();
                    if (exp_c !== o_pixel_color) begin
                        $display("%0t: pixel_color expected %h actual %h",
                                 $time, exp_c, o_pixel_color);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/ring_gauge_pixel_renderer_top_tb.sv =====
// Testbench top for the ring gauge pixel renderer: stimulus, register phases, verdict.
module ring_gauge_pixel_renderer_top_tb
    import rgpr_pkg::*;
;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        i_in_valid = 0;
    wire         o_in_ready;
    logic [9:0]  i_pixel_col = '0, i_pixel_row = '0;
    logic [15:0] i_background_color = '0;
    wire         o_out_valid;
    logic        i_out_ready = 0;
    wire  [15:0] o_pixel_color;
    int          fail_count, pending;
    int          cycles = 0;
    int          send_idle = 0, recv_stall = 0;

    always #6 i_clk = ~i_clk;

    ring_gauge_pixel_renderer_top DUT (.*);

    ring_gauge_pixel_renderer_checker u_checker (
        .*, .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[ring_gauge_pixel_renderer_top] ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall);

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // valid drops only on idle cycles or in drain, one drive per edge
    task automatic send_pixel(input logic [9:0] c, input logic [9:0] r,
                              input logic [15:0] bg);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1; i_pixel_col <= c; i_pixel_row <= r; i_background_color <= bg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_gauge(input int cc, input int cr, input int r, input int t,
                             input int v, input int mn, input int mx);
        drain();
        reg_write(REG_CENTER_COL, cc);
        reg_write(REG_CENTER_ROW, cr);
        reg_write(REG_OUTER_RADIUS, r);
        reg_write(REG_RING_THICKNESS, t);
        reg_write(REG_SHOWN_VALUE, v);
        reg_write(REG_SCALE_MIN, mn);
        reg_write(REG_SCALE_MAX, mx);
    endtask

    // mostly pixels near the ring or marker, some anywhere
    task automatic random_pixels(input int n, input int cc, input int cr, input int r);
        int c, rr, a;
        for (int k = 0; k < n; k++) begin
            a = $urandom_range(3);
            if (a == 0) begin
                c = $urandom_range(1023); rr = $urandom_range(1023);
            end else begin
                c = cc + $signed($urandom_range(2 * r + 20)) - r - 10;
                rr = cr + $signed($urandom_range(2 * r + 20)) - r - 10;
            end
            send_pixel(c[9:0], rr[9:0], 16'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: default gauge
        send_pixel(10'd0, 10'd0, 16'h0000);
        send_pixel(10'd1023, 10'd1023, 16'hFFFF);
        send_pixel(10'd239, 10'd120, 16'h1234);
        send_pixel(10'd240, 10'd120, 16'hABCD);
        send_pixel(10'd120, 10'd120, 16'h5555);
        send_pixel(10'd120, 10'd210, 16'hAAAA);
        send_pixel(10'd120, 10'd28, 16'h0F0F);
        send_pixel(10'd28, 10'd120, 16'hF0F0);
        send_pixel(10'd212, 10'd120, 16'h00FF);
        send_pixel(10'd57, 10'd183, 16'hFF00);
        send_pixel(10'd183, 10'd183, 16'h3C3C);
        send_pixel(10'd183, 10'd57, 16'hC3C3);
        send_pixel(10'd57, 10'd57, 16'h0001);
        send_pixel(10'd120, 10'd204, 16'h8000);
        // empty scale, value above scale, thickness above radius
        set_gauge(100, 100, 60, 100, 9000, 500, 500);
        send_pixel(10'd100, 10'd100, 16'h7777);
        send_pixel(10'd100, 10'd40, 16'h7777);
        send_pixel(10'd54, 10'd54, 16'h7777);
        set_gauge(100, 100, 60, 10, 65535, 0, 1000);
        send_pixel(10'd145, 10'd145, 16'h1111);
        send_pixel(10'd40, 10'd100, 16'h1111);
        random_pixels(40, 100, 100, 60);
        // random phases over several settings and idling modes
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 60; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 60; end
                3: begin send_idle = 10; recv_stall = 10; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            case (ph)
                0: set_gauge(120, 120, 100, 16, 1200, 400, 2000);
                1: set_gauge(0, 0, 511, 511, 0, 65535, 65535);
                2: set_gauge(1023, 1023, 0, 0, 65535, 0, 65535);
                3: set_gauge(120, 200, 50, 200, 300, 100, 500);
                default: set_gauge($urandom_range(239), $urandom_range(239),
                                   $urandom_range(150), $urandom_range(200),
                                   $urandom, $urandom_range(3000), $urandom_range(4000));
            endcase
            random_pixels(50, int'(u_checker.cen_col), int'(u_checker.cen_row),
                          int'(u_checker.rad) + 8);
        end
        send_idle = 0; recv_stall = 0;
        drain();
        if (fail_count == 0)
            $display("[ring_gauge_pixel_renderer_top] OK");
        else
            $display("[ring_gauge_pixel_renderer_top] ERROR");
        $finish;
    end

endmodule
